### design/matrix_inverse_4x4_top_assert.svh
// Assertion macros for the 4x4 matrix inverse block.
// Used by the port checker; no other dependencies.
`ifndef MATRIX_INVERSE_4X4_TOP_ASSERT_SVH
`define MATRIX_INVERSE_4X4_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define MI4_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mi4 assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define MI4_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mi4 assertion failed");

`endif

### design/mi4_pkg.sv
// Shared types, widths and helpers for the 4x4 matrix inverse block.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package mi4_pkg;

  // Exact widths of the intermediate values
  localparam int ELEM_W = 32;               // one matrix element
  localparam int XW     = ELEM_W + 1;       // multiplier limb operand
  localparam int PW     = XW + ELEM_W;      // multiplier product
  localparam int TW     = 65;               // 2x2 minor
  localparam int CW     = 99;               // 3x3 cofactor
  localparam int DW     = 133;              // determinant
  localparam int TLW    = (TW + 31) / 32;   // limbs of a minor
  localparam int CLW    = (CW + 31) / 32;   // limbs of a cofactor

  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  // Multiplier operand source
  typedef enum logic [1:0] {
    X_HOLD  = 2'd0,
    X_TLIMB = 2'd1,
    X_CLIMB = 2'd2
  } xsel_e;

  // Accumulator that a product lands in
  typedef enum logic [1:0] {
    T_NONE  = 2'd0,
    T_MINOR = 2'd1,
    T_COF   = 2'd2,
    T_DET   = 2'd3
  } tgt_e;

  typedef struct packed {
    tgt_e       tgt;
    logic       init;
    logic       neg;
    logic [1:0] shift;
    logic       wr;
    logic [3:0] widx;
  } acc_t;

  typedef struct packed {
    logic       mat_we;
    logic [3:0] mat_waddr;
    logic [3:0] rd_addr;
    logic       hold_ld;
    logic       mul_en;
    xsel_e      xsel;
    logic [1:0] limb;
    acc_t       acc;
    logic [3:0] cof_addr;
    logic       norm;
    logic       div_setup;
    logic       div_step;
    logic       out_load;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic singular;
  } stat_t;

  // Index n of the three that remain once index ex is removed
  function automatic logic [1:0] skip_idx(input logic [1:0] n, input logic [1:0] ex);
    return (n < ex) ? n : n + 2'd1;
  endfunction

endpackage

`default_nettype wire

### design/mi4_ctrl.sv
// Controller: load counter, cofactor/determinant sequencer, divide and emit.
// Depends on mi4_pkg; drives the datapath through cmd_t.
`default_nettype none

module mi4_ctrl import mi4_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_LOAD = 6'b000001,
    S_COF  = 6'b000010,
    S_DET  = 6'b000100,
    S_DSET = 6'b001000,
    S_DIV  = 6'b010000,
    S_EMIT = 6'b100000
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] ld_q, ld_d;
  logic [3:0] k_q, k_d;
  logic [1:0] m_q, m_d;
  logic [2:0] s_q, s_d;
  logic [4:0] step_q, step_d;

  logic [1:0] ci, cj, rr0, rr1, rr2, ca, cb, cm, lb;
  logic       sgn;

  // Row and column picks for the current cofactor and minor
  always_comb begin
    ci  = k_q[3:2];
    cj  = k_q[1:0];
    rr0 = skip_idx(2'd0, ci);
    rr1 = skip_idx(2'd1, ci);
    rr2 = skip_idx(2'd2, ci);
    ca  = skip_idx((m_q == 2'd0) ? 2'd1 : 2'd0, cj);
    cb  = skip_idx((m_q == 2'd2) ? 2'd1 : 2'd2, cj);
    cm  = skip_idx(m_q, cj);
    sgn = (m_q == 2'd1) ^ ci[0] ^ cj[0];
    lb  = 2'(s_q - 3'd5);
  end

  assign in_stall_o = (state_q != S_LOAD);

  // Sequence the commands
  always_comb begin
    state_d = state_q;
    ld_d    = ld_q;
    k_d     = k_q;
    m_d     = m_q;
    s_d     = s_q;
    step_d  = step_q;
    cmd_o   = '0;
    unique case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          cmd_o.mat_we    = 1'b1;
          cmd_o.mat_waddr = ld_q;
          ld_d            = ld_q + 4'd1;
          if (ld_q == 4'd15) begin
            state_d = S_COF;
            k_d     = '0;
            m_d     = '0;
            s_d     = '0;
          end
        end
      end
      S_COF: begin
        unique case (s_q)
          3'd0: begin
            cmd_o.rd_addr = {ca, rr1};
            cmd_o.hold_ld = 1'b1;
          end
          3'd1: begin
            cmd_o.rd_addr  = {cb, rr2};
            cmd_o.mul_en   = 1'b1;
            cmd_o.xsel     = X_HOLD;
            cmd_o.acc.tgt  = T_MINOR;
            cmd_o.acc.init = 1'b1;
          end
          3'd2: begin
            cmd_o.rd_addr = {cb, rr1};
            cmd_o.hold_ld = 1'b1;
          end
          3'd3: begin
            cmd_o.rd_addr = {ca, rr2};
            cmd_o.mul_en  = 1'b1;
            cmd_o.xsel    = X_HOLD;
            cmd_o.acc.tgt = T_MINOR;
            cmd_o.acc.neg = 1'b1;
          end
          3'd4: begin
            // let the minor settle
          end
          default: begin
            cmd_o.rd_addr   = {cm, rr0};
            cmd_o.mul_en    = 1'b1;
            cmd_o.xsel      = X_TLIMB;
            cmd_o.limb      = lb;
            cmd_o.acc.tgt   = T_COF;
            cmd_o.acc.init  = (m_q == 2'd0) && (s_q == 3'd5);
            cmd_o.acc.neg   = sgn;
            cmd_o.acc.shift = lb;
            cmd_o.acc.wr    = (m_q == 2'd2) && (s_q == 3'd7);
            cmd_o.acc.widx  = k_q;
          end
        endcase
        s_d = s_q + 3'd1;
        if (s_q == 3'd7) begin
          if (m_q == 2'd2) begin
            m_d = '0;
            k_d = k_q + 4'd1;
            if (k_q == 4'd15) begin
              state_d = S_DET;
              step_d  = '0;
            end
          end else begin
            m_d = m_q + 2'd1;
          end
        end
      end
      S_DET: begin
        if (!step_q[4]) begin
          cmd_o.cof_addr  = {step_q[3:2], 2'b00};
          cmd_o.rd_addr   = {2'b00, step_q[3:2]};
          cmd_o.mul_en    = 1'b1;
          cmd_o.xsel      = X_CLIMB;
          cmd_o.limb      = step_q[1:0];
          cmd_o.acc.tgt   = T_DET;
          cmd_o.acc.init  = (step_q == 5'd0);
          cmd_o.acc.shift = step_q[1:0];
        end
        step_d = step_q + 5'd1;
        if (step_q == 5'd17) begin
          cmd_o.norm = 1'b1;
          state_d    = S_DSET;
          k_d        = '0;
          step_d     = '0;
        end
      end
      S_DSET: begin
        cmd_o.cof_addr  = k_q;
        cmd_o.div_setup = 1'b1;
        step_d          = '0;
        state_d         = stat_i.singular ? S_EMIT : S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 5'd1;
        if (step_q == 5'd31) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = (k_q == 4'd15);
          k_d            = k_q + 4'd1;
          state_d        = (k_q == 4'd15) ? S_LOAD : S_DSET;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // Hold the control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      ld_q    <= '0;
      k_q     <= '0;
      m_q     <= '0;
      s_q     <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      ld_q    <= ld_d;
      k_q     <= k_d;
      m_q     <= m_d;
      s_q     <= s_d;
      step_q  <= step_d;
    end
  end

endmodule

`default_nettype wire

### design/mi4_datapath.sv
// Datapath: element store, shared multiplier, accumulators, cofactor store,
// restoring divider and output register. Depends on mi4_pkg.
`default_nettype none

module mi4_datapath import mi4_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [31:0] element_in_i,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic signed [31:0] element_out_o,
  output logic               is_singular_o,
  output logic               is_last_o
);

  localparam int NUMW = CW + 2 * FRACTION_BITS;
  localparam int HIW  = NUMW - 32;
  localparam int RW   = ((HIW > DW) ? HIW : DW) + 1;

  logic [31:0]           mat_q [16];
  logic [CW-1:0]         cof_q [16];
  logic [31:0]           hold_q;
  logic signed [PW-1:0]  prod_q;
  acc_t                  acc_q;
  logic [TW-1:0]         t_q, t_d;
  logic [CW-1:0]         c_q, c_d;
  logic [DW-1:0]         det_q, det_d;
  logic [DW-1:0]         dmag_q;
  logic                  dneg_q, sing_q;
  logic [RW-1:0]         rem_q;
  logic [31:0]           sr_q, q_q;
  logic                  big_q, neg_q;
  logic                  out_valid_q, out_sing_q, out_last_q;
  logic [31:0]           out_elem_q;

  logic [31:0]           y_rd;
  logic [CW-1:0]         cof_rd;
  logic [CLW*32-1:0]     t_ext, c_ext, limb_src;
  logic [31:0]           limb_bits;
  logic                  limb_top;
  logic signed [XW-1:0]  xs;
  logic signed [31:0]    ys;
  logic [DW-1:0]         add_ext, addend;
  logic [CW-1:0]         mag;
  logic [NUMW-1:0]       num;
  logic [RW-1:0]         dmag_ext, rem2;
  logic                  ge;
  logic [31:0]           res;

  assign y_rd   = mat_q[cmd_i.rd_addr];
  assign cof_rd = cof_q[cmd_i.cof_addr];
  assign t_ext  = {{(CLW*32-TW){t_q[TW-1]}}, t_q};
  assign c_ext  = {{(CLW*32-CW){cof_rd[CW-1]}}, cof_rd};

  // Select the multiplier limb; the top limb of a wide value is signed
  always_comb begin
    limb_src = t_ext;
    limb_top = 1'b0;
    unique case (cmd_i.xsel)
      X_HOLD: begin
        limb_src = {{(CLW*32-32){1'b0}}, hold_q};
        limb_top = 1'b1;
      end
      X_TLIMB: begin
        limb_src = t_ext;
        limb_top = (cmd_i.limb == 2'(TLW - 1));
      end
      X_CLIMB: begin
        limb_src = c_ext;
        limb_top = (cmd_i.limb == 2'(CLW - 1));
      end
      default: begin
        limb_src = '0;
        limb_top = 1'b0;
      end
    endcase
    if (cmd_i.xsel == X_HOLD) begin
      limb_bits = hold_q;
    end else begin
      limb_bits = limb_src[{cmd_i.limb, 5'b00000} +: 32];
    end
    xs = {limb_top & limb_bits[31], limb_bits};
    ys = y_rd;
  end

  // Shift and sign the registered product for its accumulator
  always_comb begin
    add_ext = {{(DW-PW){prod_q[PW-1]}}, prod_q};
    add_ext = add_ext << {acc_q.shift, 5'b00000};
    addend  = acc_q.neg ? (~add_ext + 1'b1) : add_ext;
    t_d     = t_q;
    c_d     = c_q;
    det_d   = det_q;
    unique case (acc_q.tgt)
      T_MINOR: t_d   = (acc_q.init ? '0 : t_q) + addend[TW-1:0];
      T_COF:   c_d   = (acc_q.init ? '0 : c_q) + addend[CW-1:0];
      T_DET:   det_d = (acc_q.init ? '0 : det_q) + addend;
      default: begin
      end
    endcase
  end

  // Numerator magnitude and one restoring step
  always_comb begin
    mag      = cof_rd[CW-1] ? (~cof_rd + 1'b1) : cof_rd;
    num      = {mag, {(2*FRACTION_BITS){1'b0}}};
    dmag_ext = {{(RW-DW){1'b0}}, dmag_q};
    rem2     = {rem_q[RW-2:0], sr_q[31]};
    ge       = (rem2 >= dmag_ext);
  end

  // Round toward zero is already done; saturate and sign the quotient
  always_comb begin
    if (sing_q) begin
      res = '0;
    end else if (neg_q) begin
      res = (big_q || (q_q > SAT_MIN)) ? SAT_MIN : (~q_q + 32'd1);
    end else begin
      res = (big_q || q_q[31]) ? SAT_MAX : q_q;
    end
  end

  // Store elements and cofactors
  always_ff @(posedge clk_i) begin
    if (cmd_i.mat_we) begin
      mat_q[cmd_i.mat_waddr] <= element_in_i;
    end
    if ((acc_q.tgt == T_COF) && acc_q.wr) begin
      cof_q[acc_q.widx] <= c_d;
    end
  end

  // Multiply, accumulate, normalize and divide
  always_ff @(posedge clk_i) begin
    if (cmd_i.hold_ld) begin
      hold_q <= y_rd;
    end
    if (cmd_i.mul_en) begin
      prod_q <= xs * ys;
    end
    t_q   <= t_d;
    c_q   <= c_d;
    det_q <= det_d;
    if (cmd_i.norm) begin
      dneg_q <= det_q[DW-1];
      dmag_q <= det_q[DW-1] ? (~det_q + 1'b1) : det_q;
    end
    if (cmd_i.div_setup) begin
      neg_q <= cof_rd[CW-1] ^ dneg_q;
      big_q <= {{(RW-HIW){1'b0}}, num[NUMW-1:32]} >= dmag_ext;
      rem_q <= {{(RW-HIW){1'b0}}, num[NUMW-1:32]};
      sr_q  <= num[31:0];
      q_q   <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? (rem2 - dmag_ext) : rem2;
      sr_q  <= {sr_q[30:0], 1'b0};
      q_q   <= {q_q[30:0], ge};
    end
    if (cmd_i.out_load) begin
      out_elem_q <= res;
      out_sing_q <= sing_q;
      out_last_q <= cmd_i.out_last;
    end
  end

  // Hold the control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      sing_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q <= cmd_i.mul_en ? cmd_i.acc : '0;
      if (cmd_i.norm) begin
        sing_q <= (det_q == '0);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign stat_o.singular = sing_q;
  assign out_valid_o     = out_valid_q;
  assign element_out_o   = out_elem_q;
  assign is_singular_o   = out_sing_q;
  assign is_last_o       = out_last_q;

endmodule

`default_nettype wire

### design/matrix_inverse_4x4_top.sv
// 4x4 matrix inverse by adjugate: one element per item in, sixteen out.
// Elements load one per cycle while loading. After the sixteenth, the cofactors are
// formed on the shared multiplier, then the determinant, and each result comes
// from the bit-serial divider, which is skipped when the matrix is singular.
// Reset (rst_ni low, asynchronous) empties the output and restarts loading.
`default_nettype none

module matrix_inverse_4x4_top import mi4_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] element_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] element_out_o,
  output logic               is_singular_o,
  output logic               is_last_o
);

  cmd_t  cmd;
  stat_t stat;

  // Sequence the work
  mi4_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Compute and hold results
  mi4_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .element_in_i  (element_in_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .element_out_o (element_out_o),
    .is_singular_o (is_singular_o),
    .is_last_o     (is_last_o)
  );

endmodule

`default_nettype wire

### design/mi4_checker.sv
// Port checker for the 4x4 matrix inverse, bound to the top level.
// Depends on the assertion macro header.
`default_nettype none

`include "matrix_inverse_4x4_top_assert.svh"

module mi4_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] element_out_o,
  input logic        is_singular_o,
  input logic        is_last_o
);

  logic        out_wait;
  logic        mid_take;
  logic [33:0] out_word;

  assign out_wait = out_valid_o && out_stall_i;
  assign mid_take = out_valid_o && !out_stall_i && !is_last_o;
  assign out_word = {element_out_o, is_singular_o, is_last_o};

  // Hold a stalled result
  `MI4_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_wait, out_valid_o && $stable(out_word))

  // Singular results carry zero
  `MI4_ASSERT_NOW(a_sing_zero, clk_i, rst_ni, out_valid_o && is_singular_o, element_out_o == '0)

  // Take no item while a result burst is still under way
  `MI4_ASSERT_NOW(a_no_load_mid_burst, clk_i, rst_ni, out_valid_o && !is_last_o, in_stall_o)

  // One singular flag for the whole burst
  `MI4_ASSERT_NEXT(a_sing_steady, clk_i, rst_ni, mid_take, !out_valid_o || $stable(is_singular_o))

endmodule

bind matrix_inverse_4x4_top mi4_checker u_mi4_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .element_out_o (element_out_o),
  .is_singular_o (is_singular_o),
  .is_last_o     (is_last_o)
);

`default_nettype wire
